FILE: hdl/mfnr_pkg.sv
package mfnr_pkg;

    // Line buffer depth and value width of the board cells.
    localparam int MAX_COLS   = 32;
    localparam int VALUE_BITS = 16;

    // Derived widths.
    localparam int COL_BITS      = $clog2(MAX_COLS);
    localparam int CNT_BITS      = $clog2(MAX_COLS + 1);
    localparam int ROW_BITS      = 12;
    localparam int COLS_CFG_BITS = 6;
    localparam int CFG_DATA_BITS = 12;
    localparam int CFG_IDX_BITS  = 1;
    localparam int SUM_BITS      = VALUE_BITS + 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOARD_ROWS = 1'b0,
        REG_BOARD_COLS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] cell_value;
        logic                  mask_bit;
    } cell_beat_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] new_value;
        logic [ROW_BITS-1:0]   out_row;
        logic [COL_BITS-1:0]   out_col;
        logic [VALUE_BITS-1:0] max_change;
        logic                  frame_last;
    } result_beat_t;

    // Board size after clipping to the supported range.
    typedef struct packed {
        logic [ROW_BITS-1:0] rows;
        logic [CNT_BITS-1:0] cols;
    } geom_t;

    // One classified cell as it waits between front and back.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  mask;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  emit;
        logic                  top_zero;
        logic                  frame_end;
    } cmd_t;

endpackage

FILE: hdl/mfnr_front.sv
module mfnr_front
    import mfnr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cell_valid,
    output logic                     cell_ready,
    input  cell_beat_t               cell_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     q_full,
    output logic                     push,
    output cmd_t                     cmd,
    output geom_t                    geom
);

    logic [ROW_BITS-1:0]      board_rows_reg;
    logic [COLS_CFG_BITS-1:0] board_cols_reg;
    logic [ROW_BITS-1:0]      row_reg, row_next;
    logic [COL_BITS-1:0]      col_reg, col_next;
    logic [ROW_BITS-1:0]      r;
    logic [COL_BITS-1:0]      c;
    logic                     last;

    always_comb
    begin
        if (board_rows_reg < ROW_BITS'(2))
            geom.rows = ROW_BITS'(2);
        else
            geom.rows = board_rows_reg;
        if (board_cols_reg < COLS_CFG_BITS'(2))
            geom.cols = CNT_BITS'(2);
        else if (board_cols_reg > COLS_CFG_BITS'(MAX_COLS))
            geom.cols = CNT_BITS'(MAX_COLS);
        else
            geom.cols = CNT_BITS'(board_cols_reg);
    end

    assign cell_ready = !q_full;
    assign push       = cell_valid && cell_ready;

    always_comb
    begin
        r = row_reg;
        c = col_reg;
        if ((row_reg >= geom.rows) || (CNT_BITS'(col_reg) >= geom.cols))
        begin
            r = '0;
            c = '0;
        end
        last = (r == geom.rows - 1'b1) && (CNT_BITS'(c) == geom.cols - 1'b1);

        if (last)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (CNT_BITS'(c) + 1'b1 >= geom.cols)
        begin
            row_next = r + 1'b1;
            col_next = '0;
        end
        else
        begin
            row_next = r;
            col_next = c + 1'b1;
        end

        cmd.value     = cell_data.cell_value;
        cmd.mask      = cell_data.mask_bit;
        cmd.row       = r - 1'b1;
        cmd.col       = c;
        cmd.emit      = (r != '0);
        cmd.top_zero  = (r == ROW_BITS'(1));
        cmd.frame_end = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_rows_reg <= ROW_BITS'(4);
            board_cols_reg <= COLS_CFG_BITS'(5);
            row_reg        <= '0;
            col_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOARD_ROWS: board_rows_reg <= ROW_BITS'(cfg_data);
                REG_BOARD_COLS: board_cols_reg <= COLS_CFG_BITS'(cfg_data);
                default:        board_rows_reg <= board_rows_reg;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: hdl/mfnr_queue.sv
module mfnr_queue
    import mfnr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t cmd_out
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

FILE: hdl/mfnr_back.sv
module mfnr_back
    import mfnr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  geom_t        geom,
    input  logic         cfg_clear,
    input  logic         q_valid,
    input  cmd_t         q_cmd,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result_data
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  emit;
        logic                  wr;
        logic                  top_zero;
        logic                  right_zero;
        logic                  last_out;
    } pipe_t;

    // Line buffers.
    logic [VALUE_BITS-1:0] line_center [MAX_COLS];
    logic [VALUE_BITS-1:0] line_above  [MAX_COLS];
    logic                  center_mask [MAX_COLS];

    logic                flush_active_reg, flush_active_next;
    logic [COL_BITS-1:0] flush_k_reg, flush_k_next;

    logic  adv;
    logic  issue;
    pipe_t a;
    logic [COL_BITS-1:0] a_right_addr;

    logic                  b_valid_reg;
    pipe_t                 b_reg;
    logic [VALUE_BITS-1:0] top_rd_reg, center_rd_reg, right_rd_reg;
    logic                  mask_rd_reg;
    logic [VALUE_BITS-1:0] prev_center_reg;
    logic [VALUE_BITS-1:0] b_top, b_left, b_right;
    logic [SUM_BITS-1:0]   b_sum;
    logic [VALUE_BITS-1:0] b_nv;

    logic                  c_valid_reg;
    pipe_t                 c_reg;
    logic [VALUE_BITS-1:0] c_nv_reg, c_old_reg;
    logic [VALUE_BITS-1:0] c_diff, c_max;
    logic                  c_load;

    logic                  out_valid_reg;
    result_beat_t          out_reg;
    logic [VALUE_BITS-1:0] max_reg;

    // The whole back pipeline moves together whenever the output register frees up.
    assign adv   = !out_valid_reg || result_ready;
    assign issue = adv && (flush_active_reg || q_valid);
    assign pop   = adv && !flush_active_reg && q_valid;

    always_comb
    begin
        a = '0;
        if (flush_active_reg)
        begin
            a.value    = '0;
            a.row      = geom.rows - 1'b1;
            a.col      = flush_k_reg;
            a.emit     = 1'b1;
            a.wr       = 1'b0;
            a.top_zero = 1'b0;
            a.last_out = (CNT_BITS'(flush_k_reg) == geom.cols - 1'b1);
        end
        else
        begin
            a.value    = q_cmd.value;
            a.row      = q_cmd.row;
            a.col      = q_cmd.col;
            a.emit     = q_cmd.emit;
            a.wr       = 1'b1;
            a.top_zero = q_cmd.top_zero;
            a.last_out = 1'b0;
        end
        a.right_zero = (CNT_BITS'(a.col) + 1'b1 >= geom.cols);
        a_right_addr = a.col + 1'b1;

        flush_active_next = flush_active_reg;
        flush_k_next      = flush_k_reg;
        if (issue && flush_active_reg)
        begin
            if (a.last_out)
                flush_active_next = 1'b0;
            else
                flush_k_next = flush_k_reg + 1'b1;
        end
        else if (pop && q_cmd.frame_end)
        begin
            flush_active_next = 1'b1;
            flush_k_next      = '0;
        end
    end

    always_comb
    begin
        b_top   = b_reg.top_zero ? '0 : top_rd_reg;
        b_left  = (b_reg.col == '0) ? '0 : prev_center_reg;
        b_right = b_reg.right_zero ? '0 : right_rd_reg;
        b_sum   = SUM_BITS'(b_top) + SUM_BITS'(b_left) + SUM_BITS'(b_right)
                + SUM_BITS'(b_reg.value);
        b_nv    = mask_rd_reg ? b_sum[SUM_BITS-1:2] : '0;
    end

    always_comb
    begin
        c_diff = (c_nv_reg >= c_old_reg) ? (c_nv_reg - c_old_reg) : (c_old_reg - c_nv_reg);
        c_max  = (c_diff > max_reg) ? c_diff : max_reg;
        c_load = adv && c_valid_reg && c_reg.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_active_reg <= 1'b0;
            flush_k_reg      <= '0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            max_reg          <= '0;
        end
        else
        begin
            flush_active_reg <= flush_active_next;
            flush_k_reg      <= flush_k_next;
            if (adv)
            begin
                b_valid_reg   <= issue;
                c_valid_reg   <= b_valid_reg;
                out_valid_reg <= c_valid_reg && c_reg.emit;
            end
            if (cfg_clear)
                max_reg <= '0;
            else if (c_load)
                max_reg <= c_reg.last_out ? '0 : c_max;
        end
    end

    // Memory ports: reads are registered, a write and a read of the same
    // entry in one cycle return the old contents.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            top_rd_reg    <= line_above[a.col];
            center_rd_reg <= line_center[a.col];
            right_rd_reg  <= line_center[a_right_addr];
            mask_rd_reg   <= center_mask[a.col];
            if (a.wr)
            begin
                line_center[a.col] <= a.value;
                center_mask[a.col] <= q_cmd.mask;
            end
        end
        if (adv && b_valid_reg && b_reg.wr)
            line_above[b_reg.col] <= center_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg <= a;
            c_reg <= b_reg;
            c_nv_reg  <= b_nv;
            c_old_reg <= center_rd_reg;
            if (b_valid_reg)
                prev_center_reg <= center_rd_reg;
        end
        if (c_load)
        begin
            out_reg.new_value  <= c_nv_reg;
            out_reg.out_row    <= c_reg.row;
            out_reg.out_col    <= c_reg.col;
            out_reg.max_change <= c_max;
            out_reg.frame_last <= c_reg.last_out;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // A flush step never updates the line buffers.
    a_flush_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && flush_active_reg) |=> (b_valid_reg && !b_reg.wr))
        else $error("flush step entered the pipeline as a buffer write");

    // The running maximum restarts after the frame's final result.
    a_max_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (c_load && c_reg.last_out) |=> (max_reg == '0))
        else $error("running maximum not cleared at frame end");

    // The frame's final result leaves only after the flush sequencer went idle.
    a_last_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (c_load && c_reg.last_out) |-> !flush_active_reg)
        else $error("frame end result while flush still running");

    // Within a frame the running maximum never falls.
    a_max_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (c_load && !c_reg.last_out && !cfg_clear) |=> (max_reg >= $past(max_reg)))
        else $error("running maximum decreased within a frame");

endmodule

FILE: hdl/masked_four_neighbour_relaxation.sv
// Streaming five-point relaxation: board cells enter one beat per cycle in raster
// order while cell_ready is high, and each result beat carries the truncated mean
// of the four neighbours of one cell (zero outside the board, or zero outright where
// the mask bit is clear), its row and column, the running maximum change of the
// frame and a frame-end flag. Results trail the input by one board row; the last
// cell of a frame releases the final row, so that beat causes board_cols + 1
// results. Sustained rate is one cell per cycle while the output accepts and no
// final row is being flushed, set by the back end taking one pass through the line
// buffers per cell. After a frame's last cell the back end emits the final row from
// the line buffers, and the input accepts at most two more cells meanwhile.
// Configuration writes restart the frame and must only be issued while idle.
module masked_four_neighbour_relaxation
    import mfnr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cell_valid,
    output logic                     cell_ready,
    input  cell_beat_t               cell_data,
    output logic                     result_valid,
    input  logic                     result_ready,
    output result_beat_t             result_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Front side: classified cells heading into the queue.
    logic  push;
    logic  q_full;
    cmd_t  front_cmd;
    geom_t geom;

    // Back side: head of the queue.
    logic q_valid;
    logic pop;
    cmd_t q_cmd;

    // The front holds the configuration and the raster counters and tags
    // each cell with the row and column of the result it releases.
    mfnr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .cmd        (front_cmd),
        .geom       (geom)
    );

    // A two-entry queue lets the front keep accepting while the back end
    // is busy flushing the last row or is held by the output side.
    mfnr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .full    (q_full),
        .pop     (pop),
        .valid   (q_valid),
        .cmd_out (q_cmd)
    );

    // The back end owns the line buffers, the averaging pipeline, the
    // running maximum and the output register.
    mfnr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .cfg_clear    (cfg_we),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

FILE: test/masked_four_neighbour_relaxation_tb.sv
module masked_four_neighbour_relaxation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mfnr_pkg::*;

    // Cycles allowed after the last expected result before a register write
    // or the end of the run. This leaves slack for cells that cause no result at all.
    localparam int SETTLE_CYCLES = 12;

    // Number of cell beats accepted before the receiver starts its long hold,
    // and the length of that hold in cycles.
    localparam int HOLD_AFTER_CELLS = 80;
    localparam int HOLD_CYCLES      = 300;

    // Random stimulus budget, and the point after which both sides stop idling.
    localparam int RANDOM_CELLS = 350;
    localparam int CALM_AFTER   = 280;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cell_valid = 1'b0;
    logic                     cell_ready;
    cell_beat_t               cell_data = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    result_beat_t             result_data;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    masked_four_neighbour_relaxation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the two line buffers, the mask line,
    // the raster position, the running peak change and the board registers.
    // ------------------------------------------------------------------
    logic [VALUE_BITS-1:0]    prev_line [MAX_COLS];
    logic [VALUE_BITS-1:0]    cur_line  [MAX_COLS];
    logic                     cur_mask  [MAX_COLS];
    int unsigned              scan_row = 0;
    int unsigned              scan_col = 0;
    logic [VALUE_BITS-1:0]    worst_change = '0;
    logic [ROW_BITS-1:0]      rows_reg = 12'd4;
    logic [COLS_CFG_BITS-1:0] cols_reg = 6'd5;

    // Result beats still owed by the block, oldest first.
    result_beat_t relaxed_expected [$];

    // Cell beats waiting for the driver.
    cell_beat_t pending_cells [$];

    int  cells_accepted = 0;
    int  mismatch_count = 0;
    int  random_sent = 0;
    bit  bursts_on = 1'b1;

    // A row count below two behaves as two.
    function automatic int unsigned live_rows();
        return (rows_reg < 2) ? 2 : rows_reg;
    endfunction

    // A column count is clipped into the range two to the line buffer depth.
    function automatic int unsigned live_cols();
        if (cols_reg < 2)
        begin
            return 2;
        end
        if (cols_reg > MAX_COLS)
        begin
            return MAX_COLS;
        end
        return cols_reg;
    endfunction

    // Forms one result beat: the truncated mean of four neighbours, or zero
    // under a clear mask bit, and folds its change into the frame's peak.
    function automatic void emit_relaxed(int unsigned row, int unsigned col,
                                         logic [VALUE_BITS-1:0] up,
                                         logic [VALUE_BITS-1:0] west,
                                         logic [VALUE_BITS-1:0] east,
                                         logic [VALUE_BITS-1:0] down,
                                         logic keep, logic [VALUE_BITS-1:0] old,
                                         logic frame_end);
        logic [SUM_BITS-1:0]   total;
        logic [VALUE_BITS-1:0] relaxed;
        logic [VALUE_BITS-1:0] delta;
        result_beat_t          beat;
        total = {2'b00, up} + {2'b00, west} + {2'b00, east} + {2'b00, down};
        relaxed = keep ? total[SUM_BITS-1:2] : '0;
        delta = (relaxed >= old) ? relaxed - old : old - relaxed;
        if (delta > worst_change)
        begin
            worst_change = delta;
        end
        beat.new_value  = relaxed;
        beat.out_row    = ROW_BITS'(row);
        beat.out_col    = COL_BITS'(col);
        beat.max_change = worst_change;
        beat.frame_last = frame_end;
        relaxed_expected.push_back(beat);
    endfunction

    // Advances the board by one accepted cell. A cell below row 0 completes
    // the cell straight above it; the last cell of the frame also releases
    // the whole final row, whose bottom neighbours lie outside the board.
    function automatic void relax_cell(cell_beat_t beat);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        logic        frame_end;
        rows = live_rows();
        cols = live_cols();
        r = scan_row;
        c = scan_col;
        if (r >= rows || c >= cols)
        begin
            r = 0;
            c = 0;
        end
        frame_end = (r == rows - 1) && (c == cols - 1);
        if (r > 0)
        begin
            // Row 0 has nothing above it, and board edges read as zero.
            emit_relaxed(r - 1, c,
                         (r == 1) ? '0 : prev_line[c],
                         (c > 0) ? prev_line[c - 1] : '0,
                         (c + 1 < cols) ? cur_line[c + 1] : '0,
                         beat.cell_value, cur_mask[c], cur_line[c], 1'b0);
        end
        prev_line[c] = cur_line[c];
        cur_line[c]  = beat.cell_value;
        cur_mask[c]  = beat.mask_bit;
        if (frame_end)
        begin
            for (int unsigned k = 0; k < cols; k++)
            begin
                emit_relaxed(rows - 1, k, prev_line[k],
                             (k > 0) ? cur_line[k - 1] : '0,
                             (k + 1 < cols) ? cur_line[k + 1] : '0,
                             '0, cur_mask[k], cur_line[k], k == cols - 1);
            end
            scan_row = 0;
            scan_col = 0;
            worst_change = '0;
        end
        else if (c + 1 >= cols)
        begin
            scan_col = 0;
            scan_row = r + 1;
        end
        else
        begin
            scan_col = c + 1;
            scan_row = r;
        end
    endfunction

    // ------------------------------------------------------------------
    // Cell driver. The next beat is loaded only when the current one has
    // been taken (or none is up), so valid never drops with a beat pending.
    // Idle bursts fall between beats while enabled.
    // ------------------------------------------------------------------
    int src_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid <= 1'b0;
            cell_data  <= '0;
            src_gap    <= 0;
        end
        else if (!cell_valid || cell_ready)
        begin
            if (src_gap > 0)
            begin
                cell_valid <= 1'b0;
                src_gap    <= src_gap - 1;
            end
            else if (pending_cells.size() == 0)
            begin
                cell_valid <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 7) == 0)
            begin
                cell_valid <= 1'b0;
                src_gap    <= $urandom_range(0, 11);
            end
            else
            begin
                cell_data  <= pending_cells.pop_front();
                cell_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready. Besides short random bursts, the receiver holds off once
    // for a long stretch while the sender keeps offering cells, so the block
    // has to fill up and push back on its input.
    // ------------------------------------------------------------------
    int  sink_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            sink_gap     <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (!hold_done && cells_accepted >= HOLD_AFTER_CELLS)
        begin
            result_ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (sink_gap > 0)
        begin
            result_ready <= 1'b0;
            sink_gap     <= sink_gap - 1;
        end
        else if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            result_ready <= 1'b0;
            sink_gap     <= $urandom_range(0, 11);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. A result beat is checked against the oldest expectation
    // before the cell beat of the same edge is fed to the predictor, so
    // the outcome never hangs on process order within a time step.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (relaxed_expected.size() == 0)
                begin
                    $error("result beat with nothing expected: row %0d col %0d value %0d",
                           result_data.out_row, result_data.out_col,
                           result_data.new_value);
                    mismatch_count++;
                end
                else
                begin
                    want = relaxed_expected.pop_front();
                    if (result_data.new_value !== want.new_value)
                    begin
                        $error("new_value: expected %0d, got %0d",
                               want.new_value, result_data.new_value);
                        mismatch_count++;
                    end
                    if (result_data.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, got %0d",
                               want.out_row, result_data.out_row);
                        mismatch_count++;
                    end
                    if (result_data.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0d, got %0d",
                               want.out_col, result_data.out_col);
                        mismatch_count++;
                    end
                    if (result_data.max_change !== want.max_change)
                    begin
                        $error("max_change: expected %0d, got %0d",
                               want.max_change, result_data.max_change);
                        mismatch_count++;
                    end
                    if (result_data.frame_last !== want.frame_last)
                    begin
                        $error("frame_last: expected %0d, got %0d",
                               want.frame_last, result_data.frame_last);
                        mismatch_count++;
                    end
                end
            end
            if (cell_valid && cell_ready)
            begin
                relax_cell(cell_data);
                cells_accepted <= cells_accepted + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Writes one board register. The block restarts its frame on any write,
    // and so does the predictor. Only called with the block idle.
    task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        if (which == REG_BOARD_ROWS)
        begin
            rows_reg = value[ROW_BITS-1:0];
        end
        else
        begin
            cols_reg = value[COLS_CFG_BITS-1:0];
        end
        scan_row = 0;
        scan_col = 0;
        worst_change = '0;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Queues random cells. Full-scale and zero values turn up often enough
    // to hit the edges of the sum, and most cells take part in relaxation.
    task automatic queue_cells(int count);
        cell_beat_t beat;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0: beat.cell_value = '0;
                1: beat.cell_value = '1;
                default: beat.cell_value = VALUE_BITS'($urandom_range(0, 65535));
            endcase
            beat.mask_bit = ($urandom_range(0, 3) != 0);
            pending_cells.push_back(beat);
        end
        random_sent += count;
    endtask

    // Waits until every queued cell has gone in and every owed result has
    // come out, then a few more cycles for cells that produce nothing.
    // Sampled on the falling edge, when all beats of the rising edge are done.
    task automatic settle_board();
        do
        begin
            @(negedge clk);
        end
        while (pending_cells.size() != 0 || cell_valid || relaxed_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned rows_pick;
        int unsigned cols_pick;
        int unsigned board_size;
        int          split;
        cell_beat_t  beat;

        for (int i = 0; i < MAX_COLS; i++)
        begin
            prev_line[i] = '0;
            cur_line[i]  = '0;
            cur_mask[i]  = 1'b0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frame on the reset board (4 rows by 5 columns). The first
        // two rows are full scale, so the middle cell of the second row sees the
        // largest possible sum. The lower rows alternate zero and full scale with
        // some mask bits clear, giving large changes and forced zeros.
        for (int i = 0; i < 20; i++)
        begin
            beat.cell_value = (i < 10 || i % 2 == 0) ? '1 : '0;
            beat.mask_bit   = (i < 10) ? 1'b1 : (i % 3 != 0);
            pending_cells.push_back(beat);
        end
        settle_board();

        // Counts below two behave as two: a two by two board, one masked cell.
        write_reg(REG_BOARD_ROWS, 12'd1);
        write_reg(REG_BOARD_COLS, 12'd0);
        for (int i = 0; i < 4; i++)
        begin
            beat.cell_value = (i == 2) ? 16'h0001 : 16'hFFFF;
            beat.mask_bit   = (i != 1);
            pending_cells.push_back(beat);
        end
        settle_board();

        // A wide board to start the random part. The long receiver hold falls
        // inside this frame while plenty of cells are still queued.
        write_reg(REG_BOARD_ROWS, 12'd6);
        write_reg(REG_BOARD_COLS, 12'd32);
        queue_cells(6 * 32);
        settle_board();

        // Random boards, each written afresh. Boards are mostly small; the
        // tallest row count only ever gets a partial frame, which the next
        // register write then abandons mid-frame.
        while (random_sent < RANDOM_CELLS)
        begin
            case ($urandom_range(0, 9))
                0: rows_pick = 0;
                1: rows_pick = 1;
                2: rows_pick = 2;
                3: rows_pick = 4095;
                default: rows_pick = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 9))
                0: cols_pick = 0;
                1: cols_pick = 1;
                2: cols_pick = 2;
                3: cols_pick = 32;
                4: cols_pick = $urandom_range(33, 63);
                5: cols_pick = 63;
                default: cols_pick = $urandom_range(3, 31);
            endcase
            // Bits above the column field are noise that the block drops.
            if ($urandom_range(0, 1) == 0)
            begin
                cols_pick += 64 * $urandom_range(0, 63);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_BOARD_ROWS, CFG_DATA_BITS'(rows_pick));
                write_reg(REG_BOARD_COLS, CFG_DATA_BITS'(cols_pick));
            end
            else
            begin
                write_reg(REG_BOARD_COLS, CFG_DATA_BITS'(cols_pick));
                write_reg(REG_BOARD_ROWS, CFG_DATA_BITS'(rows_pick));
            end
            board_size = live_rows() * live_cols();

            if (rows_pick == 4095)
            begin
                queue_cells($urandom_range(1, 3 * live_cols()));
            end
            else
            begin
                repeat ($urandom_range(1, 2))
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        // The sender stops mid-frame until the block has
                        // delivered everything owed, then carries on.
                        split = $urandom_range(1, board_size - 1);
                        queue_cells(split);
                        settle_board();
                        queue_cells(board_size - split);
                    end
                    else
                    begin
                        queue_cells(board_size);
                    end
                end
                // Sometimes leave a frame half done for the next write to cut.
                if ($urandom_range(0, 3) == 0)
                begin
                    queue_cells($urandom_range(1, board_size - 1));
                end
            end
            settle_board();
            if (random_sent > CALM_AFTER)
            begin
                bursts_on <= 1'b0;
            end
        end

        // Let any stray beats show up before the verdict.
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("masked_four_neighbour_relaxation_tb: clean");
        end
        else
        begin
            $display("masked_four_neighbour_relaxation_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including every stall.
    initial
    begin
        #40000000;
        $display("masked_four_neighbour_relaxation_tb: errors");
        $finish;
    end

endmodule
